FILE: hw/rtl/ppt_pkg.sv
// Shared constants, types and helper functions of the projective point transform.
package ppt_pkg;

	localparam int FRAC     = 16;           // fraction bits of every coordinate and matrix entry
	localparam int WW       = 66;           // exact width of a two-product sum plus offset
	localparam int NW       = WW + FRAC;    // scaled dividend width
	localparam int DIV_BITS = 50;           // quotient bits kept; larger quotients are clamped
	localparam int AW       = 67;           // width of a pre-saturation result
	localparam int LANES    = 4;            // x, y, origin x, origin y

	localparam int LANE_X  = 0;
	localparam int LANE_Y  = 1;
	localparam int LANE_OX = 2;
	localparam int LANE_OY = 3;

	localparam logic [2:0] KIND_IDENTITY    = 3'd0;
	localparam logic [2:0] KIND_TRANSLATION = 3'd1;
	localparam logic [2:0] KIND_SCALING     = 3'd2;
	localparam logic [2:0] KIND_ROTATION    = 3'd3;
	localparam logic [2:0] KIND_AFFINE      = 3'd4;
	localparam logic [2:0] KIND_PROJECTION  = 3'd5;

	localparam logic [2:0] REG_KIND   = 3'd0;
	localparam logic [2:0] REG_DIAG   = 3'd1;
	localparam logic [2:0] REG_SHEAR  = 3'd2;
	localparam logic [2:0] REG_OFFSET = 3'd3;
	localparam logic [2:0] REG_PERSP  = 3'd4;
	localparam logic [2:0] REG_W_CONST = 3'd5;
	localparam logic [2:0] REG_FLOOR  = 3'd6;

	localparam logic [63:0] DIAG_RESET    = 64'h0001_0000_0001_0000;
	localparam logic [31:0] W_CONST_RESET = 32'h0001_0000;
	localparam logic [16:0] FLOOR_RESET   = 17'd1;

	// One restoring-division step: remainder, divisor, dividend bits still to
	// shift in, and quotient bits gathered so far.
	typedef struct packed {
		logic [WW-1:0]       r;
		logic [WW-1:0]       d;
		logic [DIV_BITS-1:0] n;
		logic [DIV_BITS-1:0] q;
	} div_t;

	typedef struct packed {
		logic             op;
		logic             last;
		logic             proj;
		logic [LANES-1:0] neg;
		logic [LANES-1:0] ovf;
		logic [31:0]      aff_x;
		logic [31:0]      aff_y;
		logic             aff_sat;
	} side_t;

	// Magnitude of w raised to the floor; a zero floor acts as one.
	function automatic logic [WW-1:0] floor_mag(input logic signed [WW-1:0] w,
			input logic [16:0] e);
		logic [16:0]   ee;
		logic [WW-1:0] mag;
		logic [WW-1:0] eq;
		ee  = (e == 17'd0) ? 17'd1 : e;
		mag = w[WW-1] ? WW'(-w) : WW'(w);
		eq  = WW'(ee) << FRAC;
		return (mag < eq) ? eq : mag;
	endfunction

	// Clamp to 32 bits; bit 32 of the result flags a clamp.
	function automatic logic [32:0] sat32(input logic signed [AW-1:0] v);
		logic [AW-32:0] hi;
		hi = v[AW-1:31];
		if (hi == '0 || hi == '1)
			return {1'b0, v[31:0]};
		else
			return {1'b1, v[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF};
	endfunction

endpackage

FILE: hw/rtl/ppt_div_cell.sv
// One restoring-division cell: settles one quotient bit and hands the step on.
module ppt_div_cell (
	input  logic          clk,
	input  logic          en,
	input  ppt_pkg::div_t din,
	output ppt_pkg::div_t dout
);

	logic [ppt_pkg::WW:0]   t;
	logic [ppt_pkg::WW:0]   diff;
	logic                   ge;
	ppt_pkg::div_t          dout_q;

	assign t    = {din.r, din.n[ppt_pkg::DIV_BITS-1]};
	assign ge   = t >= {1'b0, din.d};
	assign diff = t - {1'b0, din.d};

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q.r <= ge ? diff[ppt_pkg::WW-1:0] : t[ppt_pkg::WW-1:0];
			dout_q.d <= din.d;
			dout_q.n <= {din.n[ppt_pkg::DIV_BITS-2:0], 1'b0};
			dout_q.q <= {din.q[ppt_pkg::DIV_BITS-2:0], ge};
		end
	end

	assign dout = dout_q;

endmodule

FILE: hw/rtl/ppt_div_lane.sv
// Chain of division cells producing one quotient per item.
module ppt_div_lane (
	input  logic          clk,
	input  logic          en,
	input  ppt_pkg::div_t din,
	output ppt_pkg::div_t dout
);

	ppt_pkg::div_t link [ppt_pkg::DIV_BITS+1];

	assign link[0] = din;

	for (genvar i = 0; i < ppt_pkg::DIV_BITS; i++) begin : g_cell
		ppt_div_cell u_cell (
			.clk  (clk),
			.en   (en),
			.din  (link[i]),
			.dout (link[i+1])
		);
	end

	assign dout = link[ppt_pkg::DIV_BITS];

endmodule

FILE: hw/rtl/projective_point_transform.sv
// Top level of the projective point transform: products, sums, divider chains, output.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tdata {in_y, in_x}, tuser operation, tlast in_last
//  m_*      | out       | tdata {out_y, out_x}, tuser saturated, tlast out_last
//  cfg_*    | in        | cfg_index register number, cfg_data write value
//
// One transaction is accepted per cycle while the pipeline is not held; each result
// passes through multiply, sum, divider setup, 50 division cells and the output register.
// The pipeline's depth is set by the division chains, one quotient bit per cell.
// The whole pipeline advances together: it holds while the output register is
// full and not taken, so s_tready follows m_tready combinationally.
// arst_n clears valid bits and configuration; payload registers are not reset.
module projective_point_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] in_x, [63:32] in_y
	input  logic        s_tuser,   // [0] operation
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] out_x, [63:32] out_y
	output logic        m_tuser,   // [0] saturated
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int WW  = ppt_pkg::WW;
	localparam int AW  = ppt_pkg::AW;
	localparam int FR  = ppt_pkg::FRAC;
	localparam int DB  = ppt_pkg::DIV_BITS;
	localparam int NW  = ppt_pkg::NW;

	// ---------------- configuration registers ----------------
	logic [2:0]  kind_q;
	logic [63:0] diag_q, shear_q, offset_q, persp_q;
	logic [31:0] wconst_q;
	logic [16:0] floor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= ppt_pkg::KIND_IDENTITY;
			diag_q   <= ppt_pkg::DIAG_RESET;
			shear_q  <= '0;
			offset_q <= '0;
			persp_q  <= '0;
			wconst_q <= ppt_pkg::W_CONST_RESET;
			floor_q  <= ppt_pkg::FLOOR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppt_pkg::REG_KIND:    kind_q   <= cfg_data[2:0];
				ppt_pkg::REG_DIAG:    diag_q   <= cfg_data;
				ppt_pkg::REG_SHEAR:   shear_q  <= cfg_data;
				ppt_pkg::REG_OFFSET:  offset_q <= cfg_data;
				ppt_pkg::REG_PERSP:   persp_q  <= cfg_data;
				ppt_pkg::REG_W_CONST: wconst_q <= cfg_data[31:0];
				ppt_pkg::REG_FLOOR:   floor_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	logic signed [31:0] m00, m11, m10, m01, m20, m21, m02, m12, m22;
	assign m00 = diag_q[31:0];
	assign m11 = diag_q[63:32];
	assign m10 = shear_q[31:0];
	assign m01 = shear_q[63:32];
	assign m20 = offset_q[31:0];
	assign m21 = offset_q[63:32];
	assign m02 = persp_q[31:0];
	assign m12 = persp_q[63:32];
	assign m22 = wconst_q;

	// Offsets and m22 lifted to the product scale.
	logic signed [WW-1:0] ox_w, oy_w, wc_w;
	assign ox_w = {{(WW-32-FR){m20[31]}}, m20, {FR{1'b0}}};
	assign oy_w = {{(WW-32-FR){m21[31]}}, m21, {FR{1'b0}}};
	assign wc_w = {{(WW-32-FR){m22[31]}}, m22, {FR{1'b0}}};

	logic proj;
	assign proj = kind_q[2] & (kind_q[1] | kind_q[0]);

	// Advance the whole pipeline when the output slot is free or being taken.
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---------------- stage 1: six products ----------------
	logic signed [31:0] in_x, in_y;
	assign in_x = s_tdata[31:0];
	assign in_y = s_tdata[63:32];

	logic               vld_s1, op_s1, last_s1;
	logic signed [31:0] x_s1, y_s1;
	logic signed [63:0] p00_s1, p10_s1, p01_s1, p11_s1, p02_s1, p12_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= in_x;
			y_s1    <= in_y;
			op_s1   <= s_tuser;
			last_s1 <= s_tlast;
			p00_s1  <= in_x * m00;
			p10_s1  <= in_y * m10;
			p01_s1  <= in_x * m01;
			p11_s1  <= in_y * m11;
			p02_s1  <= in_x * m02;
			p12_s1  <= in_y * m12;
		end
	end

	// ---------------- stage 2: sums and the affine paths ----------------
	logic signed [WW-1:0] p00e, p10e, p01e, p11e, p02e, p12e;
	assign p00e = WW'(p00_s1);
	assign p10e = WW'(p10_s1);
	assign p01e = WW'(p01_s1);
	assign p11e = WW'(p11_s1);
	assign p02e = WW'(p02_s1);
	assign p12e = WW'(p12_s1);

	logic                 scale_only;
	logic signed [WW-1:0] tx, ty;
	logic signed [AW-1:0] accx, accy, aff_x, aff_y;

	always_comb begin
		scale_only = !op_s1 && kind_q == ppt_pkg::KIND_SCALING;
		tx   = p00e + (scale_only ? '0 : p10e) + (op_s1 ? '0 : ox_w);
		ty   = p11e + (scale_only ? '0 : p01e) + (op_s1 ? '0 : oy_w);
		accx = (AW'(tx) + (AW'(1) <<< (FR-1))) >>> FR;
		accy = (AW'(ty) + (AW'(1) <<< (FR-1))) >>> FR;
		aff_x = accx;
		aff_y = accy;
		if (!op_s1) begin
			case (kind_q)
				ppt_pkg::KIND_IDENTITY: begin
					aff_x = AW'(x_s1);
					aff_y = AW'(y_s1);
				end
				ppt_pkg::KIND_TRANSLATION: begin
					aff_x = AW'(x_s1) + AW'(m20);
					aff_y = AW'(y_s1) + AW'(m21);
				end
				default: ;
			endcase
		end
	end

	logic                 vld_s2, op_s2, last_s2, proj_s2;
	logic signed [WW-1:0] nx_s2, ny_s2, w_s2;
	logic signed [AW-1:0] ax_s2, ay_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			last_s2 <= last_s1;
			proj_s2 <= proj;
			nx_s2   <= p00e + p10e + ox_w;
			ny_s2   <= p01e + p11e + oy_w;
			w_s2    <= p02e + p12e + wc_w;
			ax_s2   <= aff_x;
			ay_s2   <= aff_y;
		end
	end

	// ---------------- stage 3: divider setup ----------------
	logic [WW-1:0] d_main, d_orig;
	logic [WW-1:0] mag [ppt_pkg::LANES];
	logic [NW-1:0] dvd [ppt_pkg::LANES];
	logic [WW-1:0] dsr [ppt_pkg::LANES];
	logic [32:0]   sx, sy;
	logic [ppt_pkg::LANES-1:0] ovf_c;

	assign d_main = ppt_pkg::floor_mag(w_s2, floor_q);
	assign d_orig = ppt_pkg::floor_mag(wc_w, floor_q);
	assign mag[ppt_pkg::LANE_X]  = nx_s2[WW-1] ? WW'(-nx_s2) : WW'(nx_s2);
	assign mag[ppt_pkg::LANE_Y]  = ny_s2[WW-1] ? WW'(-ny_s2) : WW'(ny_s2);
	assign mag[ppt_pkg::LANE_OX] = ox_w[WW-1]  ? WW'(-ox_w)  : WW'(ox_w);
	assign mag[ppt_pkg::LANE_OY] = oy_w[WW-1]  ? WW'(-oy_w)  : WW'(oy_w);
	assign dsr[ppt_pkg::LANE_X]  = d_main;
	assign dsr[ppt_pkg::LANE_Y]  = d_main;
	assign dsr[ppt_pkg::LANE_OX] = d_orig;
	assign dsr[ppt_pkg::LANE_OY] = d_orig;
	assign sx = ppt_pkg::sat32(ax_s2);
	assign sy = ppt_pkg::sat32(ay_s2);

	ppt_pkg::div_t div_s3 [ppt_pkg::LANES];
	ppt_pkg::side_t side_s3;
	logic           vld_s3;

	for (genvar l = 0; l < ppt_pkg::LANES; l++) begin : g_setup
		assign dvd[l] = {mag[l], {FR{1'b0}}};
		// Quotient reaches 2^(DB-1) exactly when the top dividend bits reach the divisor.
		assign ovf_c[l] = WW'(dvd[l][NW-1:DB-1]) >= dsr[l];
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s3[l].r <= WW'(dvd[l][NW-1:DB]);
				div_s3[l].d <= dsr[l];
				div_s3[l].n <= dvd[l][DB-1:0];
				div_s3[l].q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.op      <= op_s2;
			side_s3.last    <= last_s2;
			side_s3.proj    <= proj_s2;
			side_s3.ovf     <= ovf_c;
			side_s3.neg[ppt_pkg::LANE_X]  <= nx_s2[WW-1] ^ w_s2[WW-1];
			side_s3.neg[ppt_pkg::LANE_Y]  <= ny_s2[WW-1] ^ w_s2[WW-1];
			side_s3.neg[ppt_pkg::LANE_OX] <= m20[31] ^ m22[31];
			side_s3.neg[ppt_pkg::LANE_OY] <= m21[31] ^ m22[31];
			side_s3.aff_x   <= sx[31:0];
			side_s3.aff_y   <= sy[31:0];
			side_s3.aff_sat <= sx[32] | sy[32];
		end
	end

	// ---------------- division chains ----------------
	ppt_pkg::div_t div_out [ppt_pkg::LANES];

	for (genvar l = 0; l < ppt_pkg::LANES; l++) begin : g_lane
		ppt_div_lane u_lane (
			.clk  (clk),
			.en   (adv),
			.din  (div_s3[l]),
			.dout (div_out[l])
		);
	end

	// Sideband rides alongside the cells.
	ppt_pkg::side_t side_q [DB];
	logic [DB-1:0]  vld_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_s3;
			for (int i = 1; i < DB; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// ---------------- output ----------------
	ppt_pkg::side_t       side_e;
	logic [DB:0]          qc [ppt_pkg::LANES];
	logic signed [DB+1:0] qs [ppt_pkg::LANES];
	logic signed [DB+2:0] rx, ry;
	logic [32:0]          px, py;

	assign side_e = side_q[DB-1];

	for (genvar l = 0; l < ppt_pkg::LANES; l++) begin : g_sign
		// Clamp an overflowed quotient to 2^(DB-1); that still saturates after the origin term.
		assign qc[l] = side_e.ovf[l] ? ((DB+1)'(1) << (DB-1)) : {1'b0, div_out[l].q};
		assign qs[l] = side_e.neg[l] ? -$signed({1'b0, qc[l]}) : $signed({1'b0, qc[l]});
	end

	assign rx = side_e.op ? (DB+3)'(qs[ppt_pkg::LANE_X]) - (DB+3)'(qs[ppt_pkg::LANE_OX])
			: (DB+3)'(qs[ppt_pkg::LANE_X]);
	assign ry = side_e.op ? (DB+3)'(qs[ppt_pkg::LANE_Y]) - (DB+3)'(qs[ppt_pkg::LANE_OY])
			: (DB+3)'(qs[ppt_pkg::LANE_Y]);
	assign px = ppt_pkg::sat32(AW'(rx));
	assign py = ppt_pkg::sat32(AW'(ry));

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tlast <= side_e.last;
			if (side_e.proj) begin
				m_tdata <= {py[31:0], px[31:0]};
				m_tuser <= px[32] | py[32];
			end else begin
				m_tdata <= {side_e.aff_y, side_e.aff_x};
				m_tuser <= side_e.aff_sat;
			end
		end
	end

	// Valid bits: advance in step with the payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_q    <= '0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			vld_s1   <= s_tvalid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_q    <= {vld_q[DB-2:0], vld_s3};
			m_tvalid <= vld_q[DB-1];
		end
	end

`ifndef SYNTHESIS
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'h7FFF_FFFF ||
			m_tdata[31:0] == 32'h8000_0000 || m_tdata[63:32] == 32'h7FFF_FFFF ||
			m_tdata[63:32] == 32'h8000_0000))
		else $error("saturated flag without a clamped coordinate");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted transaction did not enter the pipeline");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !side_s3.ovf[ppt_pkg::LANE_X]) |->
			(div_s3[ppt_pkg::LANE_X].r < div_s3[ppt_pkg::LANE_X].d))
		else $error("divider start remainder not below divisor");
`endif

endmodule
